// ===== src/amrr_pkg.sv =====
// Shared types, register codes and constants for the AMRR rate controller.
package amrr_pkg;

	localparam int unsigned MAX_RATES_DEF  = 128;
	localparam int unsigned COUNT_BITS_DEF = 16;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_THR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_THR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_RATES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_RATE = 3'd4;

	localparam logic [7:0]  MIN_THR_RST   = 8'd1;
	localparam logic [7:0]  MAX_THR_RST   = 8'd15;
	localparam logic [15:0] INTERVAL_RST  = 16'd500;
	localparam logic [7:0]  NUM_RATES_RST = 8'd8;
	localparam logic [6:0]  INIT_RATE_RST = 7'd0;

	// request codes on req_type
	localparam logic [2:0] REQ_INIT   = 3'd0;
	localparam logic [2:0] REQ_REPORT = 3'd1;
	localparam logic [2:0] REQ_SET    = 3'd2;
	localparam logic [2:0] REQ_TICK   = 3'd3;
	localparam logic [2:0] REQ_QUERY  = 3'd4;

	// adaptation constants
	localparam int unsigned MIN_FRAMES  = 10;
	localparam int unsigned SUCCESS_DIV = 10;
	localparam int unsigned FAIL_DIV    = 3;

	// rate count holds up to 256
	localparam int unsigned RCNT_W = 9;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INIT,
		OP_REPORT,
		OP_SET,
		OP_TICK,
		OP_QUERY
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  sent;
		logic [7:0]  succ_inc;
		logic [7:0]  retries;
		logic [15:0] set_sent;
		logic [15:0] set_success;
		logic [15:0] set_retries;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  min_thr;
		logic [7:0]  max_thr;
		logic [15:0] interval;
		logic [7:0]  num_rates;
		logic [6:0]  init_rate;
	} cfg_t;

	typedef struct packed {
		logic [6:0] rate_index;
		logic       rate_changed;
		logic       evaluated;
		logic [7:0] threshold_now;
	} res_t;

endpackage

// ===== src/amrr_rate_adaptation_core.sv =====
// Top level of the AMRR transmit-rate controller for one station.
// One request item per cycle is taken while in_ready is high and one result
// item per request comes back, in order. An accepted item is decoded into a
// command register, passes a two-entry queue, and the back end applies it to
// the station state and loads the result register at the same clock edge.
// The state update per item sets the sustained rate of one item per clock
// when the output side is not stalled. The queue lets intake continue while
// a result waits to be taken. Configuration writes are taken at any time
// (cfg_ready is always high) and act on state only through node init and the
// rate query; write them while the block is idle. There is no clearing pass
// after reset.
module amrr_rate_adaptation_core #(
	parameter int unsigned MAX_RATES  = amrr_pkg::MAX_RATES_DEF,
	parameter int unsigned COUNT_BITS = amrr_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [amrr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [amrr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      req_type,
	input  logic [7:0]                      frames_sent,
	input  logic [7:0]                      frames_failed,
	input  logic [7:0]                      retry_count,
	input  logic [15:0]                     set_sent,
	input  logic [15:0]                     set_success,
	input  logic [15:0]                     set_retries,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [6:0]                      rate_index,
	output logic                            rate_changed,
	output logic                            evaluated,
	output logic [7:0]                      threshold_now
);
	import amrr_pkg::*;

	cfg_t cfg_q;
	logic push_valid, push_ready;
	cmd_t push_cmd;
	logic pop_valid, pop_ready;
	cmd_t pop_cmd;
	res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_thr   <= MIN_THR_RST;
			cfg_q.max_thr   <= MAX_THR_RST;
			cfg_q.interval  <= INTERVAL_RST;
			cfg_q.num_rates <= NUM_RATES_RST;
			cfg_q.init_rate <= INIT_RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_THR:   cfg_q.min_thr   <= cfg_data[7:0];
				CFG_MAX_THR:   cfg_q.max_thr   <= cfg_data[7:0];
				CFG_INTERVAL:  cfg_q.interval  <= cfg_data[15:0];
				CFG_NUM_RATES: cfg_q.num_rates <= cfg_data[7:0];
				CFG_INIT_RATE: cfg_q.init_rate <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	amrr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.frames_sent   (frames_sent),
		.frames_failed (frames_failed),
		.retry_count   (retry_count),
		.set_sent      (set_sent),
		.set_success   (set_success),
		.set_retries   (set_retries),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_cmd      (push_cmd)
	);

	amrr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	amrr_back #(
		.MAX_RATES  (MAX_RATES),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign rate_index    = res.rate_index;
	assign rate_changed  = res.rate_changed;
	assign evaluated     = res.evaluated;
	assign threshold_now = res.threshold_now;

endmodule

// ===== src/amrr_front.sv =====
// Front end: takes request items, decodes them into commands for the queue.
module amrr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        req_type,
	input  logic [7:0]        frames_sent,
	input  logic [7:0]        frames_failed,
	input  logic [7:0]        retry_count,
	input  logic [15:0]       set_sent,
	input  logic [15:0]       set_success,
	input  logic [15:0]       set_retries,
	output logic              push_valid,
	input  logic              push_ready,
	output amrr_pkg::cmd_t    push_cmd
);
	import amrr_pkg::*;

	cmd_t cmd_d;
	cmd_t cmd_s1;
	logic valid_s1;

	always_comb begin
		cmd_d.sent        = frames_sent;
		// more failed than sent counts as no successes
		cmd_d.succ_inc    = (frames_failed > frames_sent) ? 8'd0 : frames_sent - frames_failed;
		cmd_d.retries     = retry_count;
		cmd_d.set_sent    = set_sent;
		cmd_d.set_success = set_success;
		cmd_d.set_retries = set_retries;
		case (req_type)
			REQ_INIT:   cmd_d.op = OP_INIT;
			REQ_REPORT: cmd_d.op = OP_REPORT;
			REQ_SET:    cmd_d.op = OP_SET;
			REQ_TICK:   cmd_d.op = OP_TICK;
			REQ_QUERY:  cmd_d.op = OP_QUERY;
			default:    cmd_d.op = OP_NONE;
		endcase
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// ===== src/amrr_queue.sv =====
// Short command queue between the front end and the execution back end.
module amrr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  amrr_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output amrr_pkg::cmd_t pop_cmd
);
	import amrr_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== src/amrr_back.sv =====
// Back end: station state, AMRR update and the result register.
module amrr_back #(
	parameter int unsigned MAX_RATES  = amrr_pkg::MAX_RATES_DEF,
	parameter int unsigned COUNT_BITS = amrr_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  amrr_pkg::cfg_t cfg,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  amrr_pkg::cmd_t pop_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output amrr_pkg::res_t res
);
	import amrr_pkg::*;

	localparam int unsigned CMP_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int unsigned PROD_W = COUNT_BITS + 5;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] tx_q, retry_q, succ_q, ticks_q;
	logic [COUNT_BITS-1:0] tx_d, retry_d, succ_d, ticks_d;
	logic [6:0]            rate_q, rate_d;
	logic [7:0]            thr_q, thr_d;
	logic                  rec_q, rec_d;
	logic                  eval;
	logic                  out_valid_q;
	res_t                  res_q;
	logic                  pop;

	// derived config
	logic [RCNT_W-1:0]     nr_eff, rate_cnt, last_rate;
	logic [6:0]            init_rate;
	logic [7:0]            thr_min, thr_max;
	logic [8:0]            thr_dbl_w;
	logic [7:0]            thr_dbl;

	// saturating sums
	logic [COUNT_BITS:0]   tx_sum, succ_sum, retry_sum, tick_sum, succ_one_sum;
	logic [COUNT_BITS-1:0] tx_sat, succ_sat, retry_sat, tick_sat, succ_one;
	logic [CMP_W-1:0]      ld_tx_w, ld_succ_w, ld_retry_w;
	logic [COUNT_BITS-1:0] ld_tx, ld_succ, ld_retry;

	// update decision
	logic [PROD_W-1:0]     tx_x, retry_x;
	logic                  go, is_good, is_bad, can_raise;

	assign pop       = pop_valid && pop_ready;
	assign pop_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		nr_eff    = (cfg.num_rates == 8'd0) ? RCNT_W'(1) : RCNT_W'(cfg.num_rates);
		rate_cnt  = (nr_eff > RCNT_W'(MAX_RATES)) ? RCNT_W'(MAX_RATES) : nr_eff;
		last_rate = rate_cnt - RCNT_W'(1);
		init_rate = (RCNT_W'(cfg.init_rate) > last_rate) ? last_rate[6:0] : cfg.init_rate;
		thr_min   = (cfg.min_thr == 8'd0) ? 8'd1 : cfg.min_thr;
		thr_max   = (cfg.max_thr == 8'd0) ? 8'd1 : cfg.max_thr;
		thr_dbl_w = {thr_q, 1'b0};
		thr_dbl   = (thr_dbl_w > {1'b0, thr_max}) ? thr_max : thr_dbl_w[7:0];
	end

	always_comb begin
		tx_sum       = {1'b0, tx_q} + (COUNT_BITS+1)'(pop_cmd.sent);
		succ_sum     = {1'b0, succ_q} + (COUNT_BITS+1)'(pop_cmd.succ_inc);
		retry_sum    = {1'b0, retry_q} + (COUNT_BITS+1)'(pop_cmd.retries);
		tick_sum     = {1'b0, ticks_q} + (COUNT_BITS+1)'(1);
		succ_one_sum = {1'b0, succ_q} + (COUNT_BITS+1)'(1);
		tx_sat       = tx_sum[COUNT_BITS] ? COUNT_MAX : tx_sum[COUNT_BITS-1:0];
		succ_sat     = succ_sum[COUNT_BITS] ? COUNT_MAX : succ_sum[COUNT_BITS-1:0];
		retry_sat    = retry_sum[COUNT_BITS] ? COUNT_MAX : retry_sum[COUNT_BITS-1:0];
		tick_sat     = tick_sum[COUNT_BITS] ? COUNT_MAX : tick_sum[COUNT_BITS-1:0];
		succ_one     = succ_one_sum[COUNT_BITS] ? COUNT_MAX : succ_one_sum[COUNT_BITS-1:0];
		// stats set values wider than a counter saturate
		ld_tx_w      = CMP_W'(pop_cmd.set_sent);
		ld_succ_w    = CMP_W'(pop_cmd.set_success);
		ld_retry_w   = CMP_W'(pop_cmd.set_retries);
		ld_tx        = (ld_tx_w > CMP_W'(COUNT_MAX)) ? COUNT_MAX : ld_tx_w[COUNT_BITS-1:0];
		ld_succ      = (ld_succ_w > CMP_W'(COUNT_MAX)) ? COUNT_MAX : ld_succ_w[COUNT_BITS-1:0];
		ld_retry     = (ld_retry_w > CMP_W'(COUNT_MAX)) ? COUNT_MAX : ld_retry_w[COUNT_BITS-1:0];
	end

	// retry < tx/10  <=>  tx >= 10*(retry+1);  retry > tx/3  <=>  tx < 3*retry
	always_comb begin
		tx_x      = PROD_W'(tx_q);
		retry_x   = PROD_W'(retry_q);
		is_good   = tx_x >= (retry_x + PROD_W'(1)) * PROD_W'(SUCCESS_DIV);
		is_bad    = tx_x < retry_x * PROD_W'(FAIL_DIV);
		go        = (tx_q > COUNT_BITS'(MIN_FRAMES)) &&
		            (CMP_W'(ticks_q) > CMP_W'(cfg.interval));
		can_raise = (RCNT_W'(rate_q) + RCNT_W'(1)) < rate_cnt;
	end

	always_comb begin
		tx_d    = tx_q;
		retry_d = retry_q;
		succ_d  = succ_q;
		ticks_d = ticks_q;
		rate_d  = rate_q;
		thr_d   = thr_q;
		rec_d   = rec_q;
		eval    = 1'b0;
		case (pop_cmd.op)
			OP_INIT: begin
				tx_d    = '0;
				retry_d = '0;
				succ_d  = '0;
				ticks_d = '0;
				rec_d   = 1'b0;
				thr_d   = thr_min;
				rate_d  = init_rate;
			end
			OP_REPORT: begin
				tx_d    = tx_sat;
				succ_d  = succ_sat;
				retry_d = retry_sat;
			end
			OP_SET: begin
				tx_d    = ld_tx;
				succ_d  = ld_succ;
				retry_d = ld_retry;
			end
			OP_TICK: begin
				ticks_d = tick_sat;
			end
			OP_QUERY: begin
				if (go) begin
					eval = 1'b1;
					if (is_good) begin
						succ_d = succ_one;
						if (succ_one >= COUNT_BITS'(thr_q) && can_raise) begin
							rec_d  = 1'b1;
							succ_d = '0;
							rate_d = rate_q + 7'd1;
						end else begin
							rec_d = 1'b0;
						end
					end else if (is_bad) begin
						succ_d = '0;
						if (rate_q != 7'd0) begin
							// doubled threshold only after a failed step up
							thr_d  = rec_q ? thr_dbl : thr_min;
							rate_d = rate_q - 7'd1;
						end
						rec_d = 1'b0;
					end
					tx_d    = '0;
					retry_d = '0;
					ticks_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q        <= '0;
			retry_q     <= '0;
			succ_q      <= '0;
			ticks_q     <= '0;
			rate_q      <= INIT_RATE_RST;
			thr_q       <= MIN_THR_RST;
			rec_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				tx_q    <= tx_d;
				retry_q <= retry_d;
				succ_q  <= succ_d;
				ticks_q <= ticks_d;
				rate_q  <= rate_d;
				thr_q   <= thr_d;
				rec_q   <= rec_d;
			end
			if (pop_ready) begin
				out_valid_q <= pop_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.rate_index    <= rate_d;
			res_q.rate_changed  <= (rate_d != rate_q);
			res_q.evaluated     <= eval;
			res_q.threshold_now <= thr_d;
		end
	end

	a_thr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		thr_q != 8'd0)
		else $error("success threshold reached zero");

	a_eval_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_cmd.op != OP_QUERY) |=> !res_q.evaluated)
		else $error("evaluated flag set by a non-query item");

	a_no_change_on_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (pop_cmd.op == OP_TICK || pop_cmd.op == OP_REPORT ||
		 pop_cmd.op == OP_SET || pop_cmd.op == OP_NONE)) |=> !res_q.rate_changed)
		else $error("rate changed by a counting item");

	a_cleared_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && eval) |=> (tx_q == '0 && retry_q == '0 && ticks_q == '0))
		else $error("counters not cleared after update");

	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && eval) |=> (res_q.rate_index == $past(rate_q) ||
		 res_q.rate_index == $past(rate_q) + 7'd1 ||
		 res_q.rate_index == $past(rate_q) - 7'd1))
		else $error("rate moved by more than one step");

endmodule

// ===== bench/amrr_rate_adaptation_checker.sv =====
// Checker for the AMRR rate controller: predicts each result and compares it.
`timescale 1ns / 100ps

module amrr_rate_adaptation_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [amrr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [amrr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [2:0]                      req_type,
	input  logic [7:0]                      frames_sent,
	input  logic [7:0]                      frames_failed,
	input  logic [7:0]                      retry_count,
	input  logic [15:0]                     set_sent,
	input  logic [15:0]                     set_success,
	input  logic [15:0]                     set_retries,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [6:0]                      rate_index,
	input  logic                            rate_changed,
	input  logic                            evaluated,
	input  logic [7:0]                      threshold_now,
	output int unsigned                     failures,
	output int unsigned                     results_seen
);
	import amrr_pkg::*;

	localparam int unsigned COUNT_TOP = (1 << COUNT_BITS_DEF) - 1;

	// register copies
	logic [7:0]  thr_lo;
	logic [7:0]  thr_hi;
	logic [15:0] hold_ticks;
	logic [7:0]  rate_set;
	logic [6:0]  start_rate;

	// station state
	int unsigned frames_tot;
	int unsigned retries_tot;
	int unsigned acks_tot;
	int unsigned ticks_tot;
	logic [6:0]  rate_now;
	logic [7:0]  need_now;
	logic        recovering;

	res_t rate_results_due[$];

	function automatic int unsigned clamp_count(int unsigned v);
		return (v > COUNT_TOP) ? COUNT_TOP : v;
	endfunction

	function automatic int unsigned lo_thr();
		return (thr_lo == 8'd0) ? 1 : int'(thr_lo);
	endfunction

	function automatic int unsigned hi_thr();
		return (thr_hi == 8'd0) ? 1 : int'(thr_hi);
	endfunction

	function automatic int unsigned span();
		int unsigned n;
		n = (rate_set == 8'd0) ? 1 : int'(rate_set);
		return (n > MAX_RATES_DEF) ? MAX_RATES_DEF : n;
	endfunction

	function automatic res_t next_rate_result(input logic [2:0] req, input logic [7:0] sent,
			input logic [7:0] failed, input logic [7:0] retries, input logic [15:0] s_sent,
			input logic [15:0] s_acks, input logic [15:0] s_retries);
		res_t r;
		logic [6:0] prior;
		int unsigned rix;
		int unsigned last;
		int unsigned dbl;
		prior = rate_now;
		r.evaluated = 1'b0;
		case (req)
			REQ_INIT: begin
				last = span() - 1;
				frames_tot = 0;
				retries_tot = 0;
				acks_tot = 0;
				ticks_tot = 0;
				recovering = 1'b0;
				need_now = 8'(lo_thr());
				rate_now = (int'(start_rate) > last) ? 7'(last) : start_rate;
			end
			REQ_REPORT: begin
				frames_tot = clamp_count(frames_tot + int'(sent));
				acks_tot = clamp_count(acks_tot + ((failed > sent) ? 0 : int'(sent - failed)));
				retries_tot = clamp_count(retries_tot + int'(retries));
			end
			REQ_SET: begin
				frames_tot = clamp_count(int'(s_sent));
				acks_tot = clamp_count(int'(s_acks));
				retries_tot = clamp_count(int'(s_retries));
			end
			REQ_TICK: ticks_tot = clamp_count(ticks_tot + 1);
			REQ_QUERY: begin
				if (frames_tot > MIN_FRAMES && ticks_tot > int'(hold_ticks)) begin
					r.evaluated = 1'b1;
					rix = rate_now;
					if (retries_tot < frames_tot / SUCCESS_DIV) begin
						acks_tot = clamp_count(acks_tot + 1);
						if (acks_tot >= int'(need_now) && rix + 1 < span()) begin
							recovering = 1'b1;
							acks_tot = 0;
							rix++;
						end else begin
							recovering = 1'b0;
						end
					end else if (retries_tot > frames_tot / FAIL_DIV) begin
						acks_tot = 0;
						if (rix > 0) begin
							// a failure straight after a step up backs off harder
							if (recovering) begin
								dbl = int'(need_now) * 2;
								need_now = 8'((dbl > hi_thr()) ? hi_thr() : dbl);
							end else begin
								need_now = 8'(lo_thr());
							end
							rix--;
						end
						recovering = 1'b0;
					end
					frames_tot = 0;
					retries_tot = 0;
					ticks_tot = 0;
					rate_now = 7'(rix);
				end
			end
			default: ;
		endcase
		r.rate_index = rate_now;
		r.rate_changed = (rate_now != prior);
		r.threshold_now = need_now;
		return r;
	endfunction

	function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t due;
		if (!arst_n) begin
			thr_lo = MIN_THR_RST;
			thr_hi = MAX_THR_RST;
			hold_ticks = INTERVAL_RST;
			rate_set = NUM_RATES_RST;
			start_rate = INIT_RATE_RST;
			frames_tot = 0;
			retries_tot = 0;
			acks_tot = 0;
			ticks_tot = 0;
			rate_now = INIT_RATE_RST;
			need_now = MIN_THR_RST;
			recovering = 1'b0;
			rate_results_due.delete();
			failures = 0;
			results_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (rate_results_due.size() == 0) begin
					$error("result item with none expected: rate_index %0d", rate_index);
					failures++;
				end else begin
					due = rate_results_due.pop_front();
					check_field("rate_index", 8'(due.rate_index), 8'(rate_index));
					check_field("rate_changed", 8'(due.rate_changed), 8'(rate_changed));
					check_field("evaluated", 8'(due.evaluated), 8'(evaluated));
					check_field("threshold_now", due.threshold_now, threshold_now);
				end
			end
			if (in_valid && in_ready)
				rate_results_due.push_back(next_rate_result(req_type, frames_sent,
					frames_failed, retry_count, set_sent, set_success, set_retries));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MIN_THR:   thr_lo = cfg_data[7:0];
					CFG_MAX_THR:   thr_hi = cfg_data[7:0];
					CFG_INTERVAL:  hold_ticks = cfg_data;
					CFG_NUM_RATES: rate_set = cfg_data[7:0];
					CFG_INIT_RATE: start_rate = cfg_data[6:0];
					default: ;
				endcase
			end
		end
	end

	final begin
		if (rate_results_due.size() != 0)
			$error("%0d result items never arrived", rate_results_due.size());
	end

endmodule

// ===== bench/amrr_rate_adaptation_core_test.sv =====
// Top of the AMRR rate controller bench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module amrr_rate_adaptation_core_test;
	import amrr_pkg::*;

	localparam logic [2:0] REQ_SPARE_A = 3'd5;
	localparam logic [2:0] REQ_SPARE_B = 3'd6;
	localparam logic [2:0] REQ_SPARE_C = 3'd7;
	localparam int PHASES       = 8;
	localparam int SHRINK_PHASE = 8;
	localparam int LONG_PHASE   = 9;
	localparam int PHASE_ITEMS  = 200;
	localparam int HOLD_CYCLES  = 200;

	typedef struct packed {
		logic [2:0]  req;
		logic [7:0]  sent;
		logic [7:0]  failed;
		logic [7:0]  retries;
		logic [15:0] ss;
		logic [15:0] su;
		logic [15:0] sr;
	} request_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [2:0]            req_type;
	logic [7:0]            frames_sent;
	logic [7:0]            frames_failed;
	logic [7:0]            retry_count;
	logic [15:0]           set_sent;
	logic [15:0]           set_success;
	logic [15:0]           set_retries;
	logic                  out_valid;
	logic                  out_ready;
	logic [6:0]            rate_index;
	logic                  rate_changed;
	logic                  evaluated;
	logic [7:0]            threshold_now;
	int unsigned           failures;
	int unsigned           results_seen;

	int items_offered = 0;
	int live_items = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int tick_gap = 0;

	amrr_rate_adaptation_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.frames_sent(frames_sent), .frames_failed(frames_failed), .retry_count(retry_count),
		.set_sent(set_sent), .set_success(set_success), .set_retries(set_retries),
		.out_valid(out_valid), .out_ready(out_ready), .rate_index(rate_index),
		.rate_changed(rate_changed), .evaluated(evaluated), .threshold_now(threshold_now)
	);

	amrr_rate_adaptation_checker watch (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.frames_sent(frames_sent), .frames_failed(frames_failed), .retry_count(retry_count),
		.set_sent(set_sent), .set_success(set_success), .set_retries(set_retries),
		.out_valid(out_valid), .out_ready(out_ready), .rate_index(rate_index),
		.rate_changed(rate_changed), .evaluated(evaluated), .threshold_now(threshold_now),
		.failures(failures), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic cfg_t phase_cfg(int p);
		case (p)
			0:       return '{8'd1, 8'd15, 16'd2, 8'd8, 7'd7};
			1:       return '{8'd1, 8'd15, 16'd1, 8'd8, 7'd3};
			2:       return '{8'd2, 8'd8, 16'd3, 8'd16, 7'd20};
			3:       return '{8'd0, 8'd0, 16'd0, 8'd0, 7'd5};
			4:       return '{8'd255, 8'd255, 16'd4, 8'd128, 7'd127};
			5:       return '{8'd3, 8'd255, 16'd2, 8'd200, 7'd127};
			6:       return '{8'd1, 8'd2, 16'd1, 8'd4, 7'd100};
			7:       return '{8'd5, 8'd40, 16'd1, 8'd255, 7'd60};
			8:       return '{8'd1, 8'd15, 16'd1, 8'd2, 7'd0};
			default: return '{8'd1, 8'd15, 16'd65534, 8'd8, 7'd4};
		endcase
	endfunction

	function automatic request_t item(logic [2:0] req, logic [7:0] sent, logic [7:0] failed,
			logic [7:0] retries, logic [15:0] ss, logic [15:0] su, logic [15:0] sr);
		return '{req, sent, failed, retries, ss, su, sr};
	endfunction

	function automatic request_t noise_item(logic [2:0] req);
		return '{req, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom)};
	endfunction

	// retries steered towards a clean window, a lossy one, or anything
	function automatic int unsigned pick_retries(int mood, int unsigned frames,
			int unsigned top);
		case (mood)
			0:       return $urandom_range(frames / 12);
			1:       return $urandom_range(top, frames / 2 + 1);
			default: return $urandom_range(top);
		endcase
	endfunction

	task automatic offer(request_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= it.req;
		frames_sent <= it.sent;
		frames_failed <= it.failed;
		retry_count <= it.retries;
		set_sent <= it.ss;
		set_success <= it.su;
		set_retries <= it.sr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_offered++;
		if (it.req <= REQ_QUERY) live_items++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic configure(cfg_t c);
		write_reg(CFG_MIN_THR, 16'(c.min_thr));
		write_reg(CFG_MAX_THR, 16'(c.max_thr));
		write_reg(CFG_INTERVAL, c.interval);
		write_reg(CFG_NUM_RATES, 16'(c.num_rates));
		write_reg(CFG_INIT_RATE, 16'(c.init_rate));
		cfg_valid <= 1'b0;
		tick_gap = int'(c.interval);
	endtask

	// stop offering, let every result drain, then idle the back end before going on
	task automatic settle();
		in_valid <= 1'b0;
		while (results_seen < items_offered) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly complete report or set/tick/query windows; some stray items between them
	task automatic station_round();
		request_t it;
		int mood;
		int n;
		int ticks;
		int unsigned s;
		int unsigned sent;
		if ($urandom_range(99) < 12) begin
			offer(noise_item(3'($urandom_range(7))));
			return;
		end
		mood = $urandom_range(2);
		if ($urandom_range(3) == 0) begin
			s = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(3000, 11);
			it = noise_item(REQ_SET);
			it.ss = 16'(s);
			it.sr = 16'(pick_retries(mood, s, 65535));
			offer(it);
		end else begin
			n = $urandom_range(4, 1);
			repeat (n) begin
				sent = $urandom_range(255, 3);
				it = noise_item(REQ_REPORT);
				it.sent = 8'(sent);
				it.failed = 8'(($urandom_range(7) == 0) ? $urandom_range(255)
					: $urandom_range(sent));
				it.retries = 8'(pick_retries(mood, sent, 255));
				offer(it);
			end
		end
		ticks = tick_gap + 1 + $urandom_range(1);
		if ($urandom_range(5) == 0) ticks = tick_gap;
		repeat (ticks) offer(noise_item(REQ_TICK));
		offer(noise_item(REQ_QUERY));
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_INIT;
		frames_sent = '0;
		frames_failed = '0;
		retry_count = '0;
		set_sent = '0;
		set_success = '0;
		set_retries = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(phase_cfg(0));
		offer(item(REQ_INIT, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));
		offer(item(REQ_REPORT, 8'd255, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));
		offer(item(REQ_REPORT, 8'd255, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0));
		// more failed than sent
		offer(item(REQ_REPORT, 8'd10, 8'd200, 8'd0, 16'd0, 16'd0, 16'd0));
		// counters pinned at the top, then pushed past it
		offer(item(REQ_SET, 8'd0, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		offer(item(REQ_REPORT, 8'd255, 8'd0, 8'd255, 16'd0, 16'd0, 16'd0));
		repeat (3) offer(item(REQ_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));
		offer(item(REQ_QUERY, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));
		offer(item(REQ_SPARE_A, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		offer(item(REQ_SPARE_B, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		offer(item(REQ_SPARE_C, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		// clean window steps up, lossy one straight after doubles the threshold
		offer(item(REQ_SET, 8'd0, 8'd0, 8'd0, 16'd100, 16'd0, 16'd0));
		repeat (3) offer(item(REQ_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));
		offer(item(REQ_QUERY, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));
		offer(item(REQ_SET, 8'd0, 8'd0, 8'd0, 16'd100, 16'd0, 16'd90));
		repeat (3) offer(item(REQ_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));
		offer(item(REQ_QUERY, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));
		offer(item(REQ_QUERY, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));
		offer(item(REQ_SET, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));
		offer(item(REQ_INIT, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));

		for (int p = 1; p <= PHASES; p++) begin
			settle();
			case ((p - 1) % 4)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 57; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 57; end
				default: begin idle_pct = 6;  stall_pct = 6;  end
			endcase
			configure(phase_cfg(p));
			// rate set shrinks under a running station: no node init here
			if (p != SHRINK_PHASE)
				offer(noise_item(REQ_INIT));
			if (p == 1) holds_asked++;
			target = live_items + PHASE_ITEMS;
			while (live_items < target) station_round();
		end

		// longest interval: a short run of ticks must not open the window
		settle();
		idle_pct = 0;
		stall_pct = 0;
		configure(phase_cfg(LONG_PHASE));
		offer(noise_item(REQ_INIT));
		repeat (12) offer(noise_item(REQ_TICK));
		offer(item(REQ_SET, 8'd0, 8'd0, 8'd0, 16'd20, 16'd0, 16'd0));
		offer(item(REQ_QUERY, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));

		settle();
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
src/amrr_pkg.sv
src/amrr_front.sv
src/amrr_queue.sv
src/amrr_back.sv
src/amrr_rate_adaptation_core.sv
bench/amrr_rate_adaptation_checker.sv
bench/amrr_rate_adaptation_core_test.sv
